/* design/nfs4_acl_ordered_evaluator_defines.svh */
// assertion macros for the acl evaluator
`ifndef NFS4_ACL_ORDERED_EVALUATOR_DEFINES_SVH
`define NFS4_ACL_ORDERED_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NFSACL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define NFSACL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/nfsacl_pkg.sv */
// shared types, codes and sizes of the acl evaluator
package nfsacl_pkg;

   localparam int MAX_GROUPS  = 16;
   localparam int GIDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int GCNT_W      = $clog2(MAX_GROUPS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [9:0] ENTRY_SAT = 10'd1023;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_BEGIN = 2'd2,
      REQ_ENTRY = 2'd3
   } req_kind_type;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_MODIFY = 2'd1;
   localparam logic [1:0] OP_EXEC   = 2'd2;

   localparam logic [2:0] PERM_READ  = 3'b100;
   localparam logic [2:0] PERM_WRITE = 3'b010;
   localparam logic [2:0] PERM_EXEC  = 3'b001;

   localparam logic [2:0] TAG_OWNER       = 3'd0;
   localparam logic [2:0] TAG_USER        = 3'd1;
   localparam logic [2:0] TAG_GROUP_OWNER = 3'd2;
   localparam logic [2:0] TAG_GROUP       = 3'd3;
   localparam logic [2:0] TAG_EVERYONE    = 3'd4;

   localparam logic [1:0] ACE_ALLOW = 2'd0;
   localparam logic [1:0] ACE_DENY  = 2'd1;

   localparam logic [2:0] REASON_ROOT    = 3'd0;
   localparam logic [2:0] REASON_NO_EXEC = 3'd1;
   localparam logic [2:0] REASON_DENY    = 3'd2;
   localparam logic [2:0] REASON_ALLOW   = 3'd3;
   localparam logic [2:0] REASON_UNSAT   = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] id_value;
      logic [31:0] owner_gid;
      logic        is_dir;
      logic [1:0]  op_kind;
      logic        is_traverse;
      logic        mode_has_exec;
      logic [2:0]  ace_tag;
      logic [1:0]  ace_type;
      logic        ace_inherit;
      logic [2:0]  ace_perms;
      logic        ace_last;
   } req_word_type;

   typedef struct packed {
      logic        allowed;
      logic [2:0]  reason;
      logic [9:0]  entry_number;
      logic [2:0]  bits_left;
   } rsp_word_type;

   typedef struct packed {
      req_kind_type kind;
      logic [31:0]  id_value;
      logic [31:0]  owner_gid;
      logic [2:0]   want_bits;
      logic         no_exec_deny;
      logic [2:0]   ace_tag;
      logic [1:0]   ace_type;
      logic         ace_inherit;
      logic [2:0]   ace_perms;
      logic         ace_last;
   } work_type;

   typedef struct packed {
      logic     push_valid;
      work_type push_word;
   } push_type;

   typedef struct packed {
      logic     pop_valid;
      work_type pop_word;
   } pop_type;

endpackage

/* design/nfsacl_ram.sv */
// generic single-port-write ram with registered read
module nfsacl_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/nfsacl_front.sv */
// front end: accepts request words and classifies them for the queue
module nfsacl_front (
   input  logic                    req_valid,
   input  nfsacl_pkg::req_word_type req_word,
   output logic                    req_stall,
   output nfsacl_pkg::push_type    push,
   input  logic                    queue_full
);
   import nfsacl_pkg::*;

   work_type   word;
   logic [2:0] want;

   always_comb begin
      want = '0;
      if (req_word.is_traverse || req_word.op_kind == OP_EXEC) begin
         want = want | PERM_EXEC;
      end
      if (!req_word.is_traverse && req_word.op_kind == OP_READ) begin
         want = want | PERM_READ;
      end
      if (!req_word.is_traverse && req_word.op_kind == OP_MODIFY) begin
         want = want | PERM_WRITE;
      end

      word.kind         = req_kind_type'(req_word.req_type);
      word.id_value     = req_word.id_value;
      word.owner_gid    = req_word.owner_gid;
      word.want_bits    = want;
      word.no_exec_deny = !req_word.is_dir && req_word.op_kind == OP_EXEC &&
                          !req_word.mode_has_exec;
      word.ace_tag      = req_word.ace_tag;
      word.ace_type     = req_word.ace_type;
      word.ace_inherit  = req_word.ace_inherit;
      word.ace_perms    = req_word.ace_perms;
      word.ace_last     = req_word.ace_last;
   end

   assign push.push_valid = req_valid;
   assign push.push_word  = word;
   assign req_stall       = queue_full;

endmodule

/* design/nfsacl_queue.sv */
// short fifo between front end and back end
module nfsacl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  nfsacl_pkg::push_type push,
   output logic                 full,
   output nfsacl_pkg::pop_type  head,
   input  logic                 pop
);
   import nfsacl_pkg::*;

   work_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign do_push = push.push_valid && !full;
   assign do_pop  = pop && count_ff != '0;

   assign head.pop_valid = count_ff != '0;
   assign head.pop_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.push_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/nfsacl_back.sv */
// back end: group list, check state, group scan and result register
module nfsacl_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [31:0]              user_uid,
   input  nfsacl_pkg::pop_type      head,
   output logic                     pop,
   output logic                     rsp_valid,
   output nfsacl_pkg::rsp_word_type rsp_word,
   input  logic                     rsp_stall
);
   import nfsacl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_COMPARE,
      S_EXEC
   } state_type;

   state_type         state_ff, state_in;
   work_type          cur_ff, cur_in;
   logic              match_ff, match_in;
   logic [GIDX_W-1:0] idx_ff, idx_in;
   logic [31:0]       target_ff, target_in;
   logic [GCNT_W-1:0] group_count_ff, group_count_in;
   logic [31:0]       object_owner_ff, object_owner_in;
   logic [31:0]       object_group_ff, object_group_in;
   logic [2:0]        remaining_ff, remaining_in;
   logic              active_ff, active_in;
   logic [9:0]        entry_cnt_ff, entry_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              ram_we;
   logic [31:0]       ram_rdata;

   logic              out_free;
   logic              direct_match;
   logic              needs_scan;
   logic              hit;
   logic              last_idx;
   logic [9:0]        cnt_next;
   logic [2:0]        overlap;
   logic [2:0]        rem_after;
   logic              hit_entry;
   logic              apply_allow;
   logic [2:0]        rem_new;

   nfsacl_ram #(
      .WIDTH (32),
      .DEPTH (MAX_GROUPS)
   ) u_group_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (group_count_ff[GIDX_W-1:0]),
      .wr_data (cur_ff.id_value),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (head.pop_word.ace_tag)
         TAG_OWNER:    direct_match = user_uid == object_owner_ff;
         TAG_USER:     direct_match = head.pop_word.id_value == user_uid;
         TAG_EVERYONE: direct_match = 1'b1;
         default:      direct_match = 1'b0;
      endcase
   end

   assign needs_scan = head.pop_word.kind == REQ_ENTRY && active_ff &&
                       !head.pop_word.ace_inherit &&
                       (head.pop_word.ace_tag == TAG_GROUP_OWNER ||
                        head.pop_word.ace_tag == TAG_GROUP) &&
                       group_count_ff != '0;

   assign hit      = ram_rdata == target_ff;
   assign last_idx = (GCNT_W'(idx_ff) + GCNT_W'(1)) == group_count_ff;

   assign cnt_next    = (entry_cnt_ff < ENTRY_SAT) ? entry_cnt_ff + 10'd1 : entry_cnt_ff;
   assign overlap     = remaining_ff & cur_ff.ace_perms;
   assign rem_after   = remaining_ff & ~cur_ff.ace_perms;
   assign hit_entry   = !cur_ff.ace_inherit && match_ff && overlap != '0;
   assign apply_allow = hit_entry && cur_ff.ace_type == ACE_ALLOW;
   assign rem_new     = apply_allow ? rem_after : remaining_ff;

   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      match_in        = match_ff;
      idx_in          = idx_ff;
      target_in       = target_ff;
      group_count_in  = group_count_ff;
      object_owner_in = object_owner_ff;
      object_group_in = object_group_ff;
      remaining_in    = remaining_ff;
      active_in       = active_ff;
      entry_cnt_in    = entry_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;
      pop             = 1'b0;
      ram_we          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head.pop_valid) begin
               pop       = 1'b1;
               cur_in    = head.pop_word;
               idx_in    = '0;
               match_in  = direct_match;
               target_in = (head.pop_word.ace_tag == TAG_GROUP_OWNER) ?
                           object_group_ff : head.pop_word.id_value;
               state_in  = needs_scan ? S_READ : S_EXEC;
            end
         end
         S_READ: begin
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            if (hit || last_idx) begin
               match_in = hit;
               state_in = S_EXEC;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               unique case (cur_ff.kind)
                  REQ_CLEAR: begin
                     group_count_in = '0;
                  end
                  REQ_ADD: begin
                     if (group_count_ff < GCNT_W'(MAX_GROUPS)) begin
                        ram_we         = 1'b1;
                        group_count_in = group_count_ff + 1'b1;
                     end
                  end
                  REQ_BEGIN: begin
                     object_owner_in = cur_ff.id_value;
                     object_group_in = cur_ff.owner_gid;
                     entry_cnt_in    = '0;
                     remaining_in    = cur_ff.want_bits;
                     active_in       = 1'b0;
                     if (user_uid == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '{1'b1, REASON_ROOT, 10'd0, cur_ff.want_bits};
                     end else if (cur_ff.no_exec_deny) begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '{1'b0, REASON_NO_EXEC, 10'd0, cur_ff.want_bits};
                     end else begin
                        active_in = 1'b1;
                     end
                  end
                  REQ_ENTRY: begin
                     if (active_ff) begin
                        entry_cnt_in = cnt_next;
                        if (hit_entry && cur_ff.ace_type == ACE_DENY) begin
                           active_in    = 1'b0;
                           rsp_valid_in = 1'b1;
                           rsp_word_in  = '{1'b0, REASON_DENY, cnt_next, remaining_ff};
                        end else if (apply_allow && rem_after == '0) begin
                           remaining_in = '0;
                           active_in    = 1'b0;
                           rsp_valid_in = 1'b1;
                           rsp_word_in  = '{1'b1, REASON_ALLOW, cnt_next, 3'd0};
                        end else begin
                           remaining_in = rem_new;
                           if (cur_ff.ace_last) begin
                              active_in    = 1'b0;
                              rsp_valid_in = 1'b1;
                              rsp_word_in  = '{1'b0, REASON_UNSAT, cnt_next, rem_new};
                           end
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff          <= cur_in;
      match_ff        <= match_in;
      idx_ff          <= idx_in;
      target_ff       <= target_in;
      object_owner_ff <= object_owner_in;
      object_group_ff <= object_group_in;
      remaining_ff    <= remaining_in;
      entry_cnt_ff    <= entry_cnt_in;
      rsp_word_ff     <= rsp_word_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         group_count_ff <= '0;
         active_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         group_count_ff <= group_count_in;
         active_ff      <= active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* design/nfs4_acl_ordered_evaluator.sv */
// top level of the ordered nfsv4 acl access evaluator
//
//  channel  direction  handshake            word
//  req_     in         req_valid/req_stall  req_word (clear, add group, begin, entry)
//  rsp_     out        rsp_valid/rsp_stall  rsp_word (decision)
//  csr_     in         csr_we               csr_wdata (user uid)
//
// a word passes through the back end's idle and execute steps; a group entry adds a read step
// and a compare step per group list slot scanned (one ram read plus compare, up to the group count)
// a four-word queue lets the front keep accepting while the back end scans or waits
// synchronous active-high reset clears control state; the group ram is not cleared
// a waiting result under rsp_stall holds every word at the back end's execute step

`include "nfs4_acl_ordered_evaluator_defines.svh"

module nfs4_acl_ordered_evaluator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  nfsacl_pkg::req_word_type req_word,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output nfsacl_pkg::rsp_word_type rsp_word,
   input  logic                     rsp_stall,
   input  logic                     csr_we,
   input  logic [31:0]              csr_wdata
);
   import nfsacl_pkg::*;

   logic [31:0] user_uid_ff, user_uid_in;
   push_type    q_push;
   pop_type     q_head;
   logic        q_full;
   logic        q_pop;

   assign user_uid_in = csr_we ? csr_wdata : user_uid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         user_uid_ff <= '0;
      end else begin
         user_uid_ff <= user_uid_in;
      end
   end

   nfsacl_front u_front (
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_stall  (req_stall),
      .push       (q_push),
      .queue_full (q_full)
   );

   nfsacl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .head  (q_head),
      .pop   (q_pop)
   );

   nfsacl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .user_uid  (user_uid_ff),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

   `NFSACL_ASSERT_IMP(a_allowed_reason, clock, reset, rsp_valid, rsp_word.allowed == (rsp_word.reason == REASON_ROOT || rsp_word.reason == REASON_ALLOW), "allowed disagrees with reason")
   `NFSACL_ASSERT_IMP(a_begin_entry_zero, clock, reset, rsp_valid && (rsp_word.reason == REASON_ROOT || rsp_word.reason == REASON_NO_EXEC), rsp_word.entry_number == 10'd0, "begin decision carries an entry number")
   `NFSACL_ASSERT_IMP(a_full_allow_bits, clock, reset, rsp_valid && rsp_word.reason == REASON_ALLOW, rsp_word.bits_left == 3'd0, "full allow with bits left")
   `NFSACL_ASSERT_NXT(a_single_pop, clock, reset, q_pop && q_head.pop_valid, !q_pop, "back end popped two words in a row")

endmodule

/* bench/tb_nfs4_acl_ordered_evaluator.sv */
// testbench for the ordered nfsv4 acl access evaluator: predicted decisions vs rtl
`timescale 1ns / 1ps

import nfsacl_pkg::*;

class acl_verdict_tracker;
   logic [31:0]  user_id;
   logic [31:0]  member_gids [MAX_GROUPS];
   int unsigned  member_count;
   logic [31:0]  obj_owner;
   logic [31:0]  obj_group;
   logic [2:0]   wanted;
   bit           check_open;
   logic [9:0]   ordinal;
   rsp_word_type awaited [$];
   int unsigned  mismatches;
   int unsigned  verdicts;

   function new();
      user_id      = '0;
      member_count = 0;
      obj_owner    = '0;
      obj_group    = '0;
      wanted       = '0;
      check_open   = 1'b0;
      ordinal      = '0;
      mismatches   = 0;
      verdicts     = 0;
   endfunction

   function bit is_member(logic [31:0] gid);
      for (int i = 0; i < member_count; i++) begin
         if (member_gids[i] == gid) return 1'b1;
      end
      return 1'b0;
   endfunction

   function void post_verdict(logic ok, logic [2:0] why, logic [9:0] num, logic [2:0] bits);
      awaited.push_back(rsp_word_type'{allowed: ok, reason: why, entry_number: num,
                                       bits_left: bits});
   endfunction

   // returns 0 only for a word the block ignores
   function bit note_request(req_word_type w);
      logic [2:0] want;
      logic [2:0] overlap;
      bit         hit;
      case (req_kind_type'(w.req_type))
         REQ_CLEAR: member_count = 0;
         REQ_ADD: begin
            if (member_count < MAX_GROUPS) begin
               member_gids[member_count] = w.id_value;
               member_count++;
            end
         end
         REQ_BEGIN: begin
            obj_owner  = w.id_value;
            obj_group  = w.owner_gid;
            ordinal    = '0;
            check_open = 1'b0;
            want       = '0;
            if (w.is_traverse || w.op_kind == OP_EXEC) want |= PERM_EXEC;
            if (!w.is_traverse && w.op_kind == OP_READ) want |= PERM_READ;
            if (!w.is_traverse && w.op_kind == OP_MODIFY) want |= PERM_WRITE;
            wanted = want;
            if (user_id == '0)
               post_verdict(1'b1, REASON_ROOT, '0, want);
            else if (!w.is_dir && w.op_kind == OP_EXEC && !w.mode_has_exec)
               post_verdict(1'b0, REASON_NO_EXEC, '0, want);
            else
               check_open = 1'b1;
         end
         default: begin
            if (!check_open) return 1'b0;
            if (ordinal != ENTRY_SAT) ordinal++;
            if (!w.ace_inherit) begin
               case (w.ace_tag)
                  TAG_OWNER:       hit = (user_id == obj_owner);
                  TAG_USER:        hit = (w.id_value == user_id);
                  TAG_GROUP_OWNER: hit = is_member(obj_group);
                  TAG_GROUP:       hit = is_member(w.id_value);
                  TAG_EVERYONE:    hit = 1'b1;
                  default:         hit = 1'b0;
               endcase
               overlap = wanted & w.ace_perms;
               if (hit && overlap != '0) begin
                  if (w.ace_type == ACE_DENY) begin
                     check_open = 1'b0;
                     post_verdict(1'b0, REASON_DENY, ordinal, wanted);
                     return 1'b1;
                  end
                  if (w.ace_type == ACE_ALLOW) begin
                     wanted &= ~overlap;
                     if (wanted == '0) begin
                        check_open = 1'b0;
                        post_verdict(1'b1, REASON_ALLOW, ordinal, '0);
                        return 1'b1;
                     end
                  end
               end
            end
            if (w.ace_last) begin
               check_open = 1'b0;
               post_verdict(1'b0, REASON_UNSAT, ordinal, wanted);
            end
         end
      endcase
      return 1'b1;
   endfunction

   function void report(string what, logic [31:0] want_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
   endfunction

   function void check_verdict(rsp_word_type got);
      rsp_word_type exp;
      verdicts++;
      if (awaited.size() == 0) begin
         report("unexpected word, allowed", 'x, got.allowed);
         return;
      end
      exp = awaited.pop_front();
      if (got.allowed !== exp.allowed) report("allowed", exp.allowed, got.allowed);
      if (got.reason !== exp.reason) report("reason", exp.reason, got.reason);
      if (got.entry_number !== exp.entry_number)
         report("entry_number", exp.entry_number, got.entry_number);
      if (got.bits_left !== exp.bits_left) report("bits_left", exp.bits_left, got.bits_left);
   endfunction
endclass

module tb_nfs4_acl_ordered_evaluator;

   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          DRAIN_CYCLES = 256;
   localparam logic [1:0]  OP_UNKNOWN   = 2'd3;
   localparam logic [2:0]  TAG_OTHER    = 3'd5;
   localparam logic [1:0]  ACE_AUDIT    = 2'd2;
   localparam logic [1:0]  ACE_ALARM    = 2'd3;
   localparam logic [31:0] POOL_BASE    = 32'h0000_1000;
   localparam logic [31:0] DIR_GROUP    = 32'h1234_5678;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   req_word_type req_word  = '0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         rsp_stall = 1'b0;
   logic         csr_we    = 1'b0;
   logic [31:0]  csr_wdata = '0;

   acl_verdict_tracker board = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_done     = 0;
   int uid_settings   = 0;
   int cycles         = 0;

   nfs4_acl_ordered_evaluator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("nfs4_acl_ordered_evaluator verification failed");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) board.check_verdict(rsp_word);
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   function automatic req_word_type random_word();
      req_word_type w;
      logic [31:0]  a;
      logic [31:0]  b;
      a = $urandom;
      b = $urandom;
      w.req_type      = a[1:0];
      w.id_value      = $urandom;
      w.owner_gid     = $urandom;
      w.is_dir        = a[2];
      w.op_kind       = a[4:3];
      w.is_traverse   = a[5];
      w.mode_has_exec = a[6];
      w.ace_tag       = a[9:7];
      w.ace_type      = a[11:10];
      w.ace_inherit   = a[12];
      w.ace_perms     = b[2:0];
      w.ace_last      = b[3];
      return w;
   endfunction

   function automatic req_word_type make_group(req_kind_type kind, logic [31:0] id);
      req_word_type w;
      w          = random_word();
      w.req_type = kind;
      w.id_value = id;
      return w;
   endfunction

   function automatic req_word_type make_begin(logic [31:0] owner, logic [31:0] gid,
                                               logic dir, logic [1:0] op, logic trav,
                                               logic hasx);
      req_word_type w;
      w               = random_word();
      w.req_type      = REQ_BEGIN;
      w.id_value      = owner;
      w.owner_gid     = gid;
      w.is_dir        = dir;
      w.op_kind       = op;
      w.is_traverse   = trav;
      w.mode_has_exec = hasx;
      return w;
   endfunction

   function automatic req_word_type make_entry(logic [2:0] tag, logic [1:0] kind, logic inh,
                                               logic [2:0] perms, logic last,
                                               logic [31:0] id);
      req_word_type w;
      w              = random_word();
      w.req_type     = REQ_ENTRY;
      w.ace_tag      = tag;
      w.ace_type     = kind;
      w.ace_inherit  = inh;
      w.ace_perms    = perms;
      w.ace_last     = last;
      w.id_value     = id;
      return w;
   endfunction

   // ids biased toward the current user, a small group pool and the extremes
   function automatic logic [31:0] pick_id();
      int k;
      k = $urandom_range(9);
      if (k < 4) return board.user_id;
      if (k < 6) return POOL_BASE + $urandom_range(3);
      if (k == 6) return '0;
      if (k == 7) return '1;
      return $urandom;
   endfunction

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_word  <= random_word();
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      void'(board.note_request(w));
      items_done++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_user(input logic [31:0] uid);
      csr_we    <= 1'b1;
      csr_wdata <= uid;
      @(posedge clock);
      csr_we        <= 1'b0;
      board.user_id  = uid;
      uid_settings++;
   endtask

   task automatic run_sequence();
      int           k;
      int           n;
      logic [1:0]   op;
      logic [2:0]   tag;
      logic [1:0]   kind;
      logic [31:0]  a;
      k = $urandom_range(99);
      if (k < 8) begin
         n = $urandom_range(3, 1);
         repeat (n) send_word(random_word());
      end else if (k < 25) begin
         if ($urandom_range(1) == 0) send_word(make_group(REQ_CLEAR, $urandom));
         n = ($urandom_range(9) == 0) ? 20 : $urandom_range(5, 1);
         repeat (n) send_word(make_group(REQ_ADD, pick_id()));
      end else begin
         k  = $urandom_range(9);
         op = (k == 0) ? OP_UNKNOWN : (k < 4) ? OP_READ : (k < 7) ? OP_MODIFY : OP_EXEC;
         a  = $urandom;
         send_word(make_begin(pick_id(), pick_id(), a[0], op, a[2:1] == 2'b00, a[3]));
         n = $urandom_range(8, 1);
         for (int i = 0; i < n; i++) begin
            k = $urandom_range(11);
            if (k < 10) tag = 3'(k % 5);
            else tag = 3'($urandom_range(7, 5));
            kind = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
            a = $urandom;
            send_word(make_entry(tag, kind, $urandom_range(9) == 0, a[2:0],
                                 (i == n - 1) ^ ($urandom_range(19) == 0), pick_id()));
         end
      end
   endtask

   task automatic run_phase(input logic [31:0] uid, input int count);
      int target;
      settle();
      set_user(uid);
      target = items_done + count;
      while (items_done < target) run_sequence();
   endtask

   initial begin
      logic [31:0] uid;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 31;
      recv_stall_pct = 83;

      // directed: bypass, no exec bits, skipped entries, unknown op, abandoned check
      set_user('0);
      send_word(make_begin('0, '0, 1'b0, OP_READ, 1'b0, 1'b0));
      send_word(make_begin('0, '0, 1'b0, OP_EXEC, 1'b1, 1'b0));
      settle();
      set_user('1);
      send_word(make_begin('1, DIR_GROUP, 1'b0, OP_EXEC, 1'b0, 1'b0));
      send_word(make_begin('1, DIR_GROUP, 1'b0, OP_EXEC, 1'b1, 1'b0));
      send_word(make_entry(TAG_EVERYONE, ACE_ALLOW, 1'b0, PERM_EXEC, 1'b1, '0));
      send_word(make_begin('1, DIR_GROUP, 1'b0, OP_READ, 1'b1, 1'b0));
      send_word(make_entry(TAG_EVERYONE, ACE_ALLOW, 1'b0, PERM_EXEC, 1'b1, '0));
      send_word(make_group(REQ_CLEAR, '0));
      send_word(make_group(REQ_ADD, DIR_GROUP));
      send_word(make_begin('1, DIR_GROUP, 1'b1, OP_MODIFY, 1'b0, 1'b0));
      send_word(make_entry(TAG_EVERYONE, ACE_AUDIT, 1'b0, 3'b111, 1'b0, '0));
      send_word(make_entry(TAG_EVERYONE, ACE_ALARM, 1'b0, 3'b111, 1'b0, '0));
      send_word(make_entry(TAG_EVERYONE, ACE_DENY, 1'b1, 3'b111, 1'b0, '0));
      send_word(make_entry(TAG_OTHER, ACE_DENY, 1'b0, 3'b111, 1'b0, '1));
      send_word(make_entry(TAG_OWNER, ACE_DENY, 1'b0, PERM_READ, 1'b0, '0));
      send_word(make_entry(TAG_GROUP_OWNER, ACE_ALLOW, 1'b0, PERM_WRITE, 1'b0, '0));
      send_word(make_begin('0, DIR_GROUP, 1'b1, OP_UNKNOWN, 1'b0, 1'b0));
      send_word(make_entry(TAG_EVERYONE, ACE_ALLOW, 1'b0, 3'b111, 1'b1, '0));
      send_word(make_begin('0, DIR_GROUP, 1'b0, OP_READ, 1'b0, 1'b1));
      send_word(make_entry(TAG_USER, ACE_DENY, 1'b0, 3'b111, 1'b0, '1));
      send_word(make_begin('0, '0, 1'b0, OP_EXEC, 1'b0, 1'b1));
      send_word(make_entry(TAG_GROUP, ACE_ALLOW, 1'b0, PERM_EXEC, 1'b0, DIR_GROUP));
      send_word(make_begin('0, '0, 1'b0, OP_READ, 1'b0, 1'b0));
      send_word(make_begin('0, '0, 1'b0, OP_MODIFY, 1'b0, 1'b0));
      send_word(make_entry(TAG_OWNER, ACE_ALLOW, 1'b0, 3'b111, 1'b1, '0));

      run_phase('1, 150);
      uid = $urandom;
      if (uid == '0) uid = 32'd1;
      run_phase(uid, 150);

      send_idle_pct  = 83;
      recv_stall_pct = 31;
      run_phase('0, 100);
      run_phase(32'd1, 150);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_phase(32'h8000_0000, 170);
      uid = $urandom;
      if (uid == '0) uid = 32'd2;
      run_phase(uid, 170);

      // long acl with no match: ordinal saturates
      send_word(make_begin('0, '0, 1'b1, OP_READ, 1'b0, 1'b0));
      for (int i = 0; i < 1030; i++)
         send_word(make_entry(TAG_OTHER, ACE_ALLOW, 1'b0, 3'b111, i == 1029, '0));

      settle();
      $display("ran %0d accepted words under %0d user id settings and three pacing modes",
               items_done, uid_settings);
      $display("checked %0d decisions, %0d mismatches", board.verdicts, board.mismatches);
      if (board.mismatches == 0 && board.awaited.size() == 0)
         $display("nfs4_acl_ordered_evaluator verification clean");
      else
         $display("nfs4_acl_ordered_evaluator verification failed");
      $finish;
   end

endmodule
